FILE: rtl/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg: constants for the modular power unit
// Field widths, the fixed prime, exponent length and the Barrett constant.
// ----------------------------------------------------------------------------
package mpp_pkg;

    localparam int MOD_W    = 30;
    localparam int EXP_IN_W = 32;
    localparam int EXP_BITS = 32;

    localparam int MUL_W  = MOD_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = 2 * MOD_W;
    localparam int REM_W  = MOD_W + 2;
    localparam int CNT_W  = $clog2(EXP_BITS + 1);

    localparam logic [63:0] PRIME_FULL = 64'd1000000007;
    localparam logic [MOD_W-1:0] PRIME_MOD = PRIME_FULL[MOD_W-1:0];

    localparam logic [63:0] BARRETT_FULL = (64'd1 << SQ_W) / PRIME_FULL;
    localparam logic [MUL_W-1:0] BARRETT_M = BARRETT_FULL[MUL_W-1:0];

    localparam logic [63:0] PRIME_X2_FULL = 64'd2 * PRIME_FULL;
    localparam logic [63:0] PRIME_X3_FULL = 64'd3 * PRIME_FULL;
    localparam logic [REM_W-1:0] PRIME_R  = PRIME_FULL[REM_W-1:0];
    localparam logic [REM_W-1:0] PRIME_X2 = PRIME_X2_FULL[REM_W-1:0];
    localparam logic [REM_W-1:0] PRIME_X3 = PRIME_X3_FULL[REM_W-1:0];

endpackage

FILE: rtl/modular_power_prime_unit.sv
// ----------------------------------------------------------------------------
// modular_power_prime_unit: base^exponent modulo 1000000007
// Left-to-right square-and-multiply over one shared multiplier with
// Barrett reduction.
//
// channel  | ports                    | handshake
// ---------+--------------------------+-------------------------------
// item in  | base[29:0] exponent[31:0] | start high while busy low
// result   | power[29:0]              | done high for one cycle
//
// Each modular multiply runs in steps on the single 31x31 multiplier:
// product, quotient estimate, quotient times prime, correction.
// An item squares once per exponent bit and multiplies once per set bit.
// busy falls in the cycle that done is shown; a new item may start then.
// Reset is asynchronous, active low, and returns the unit to idle.
// The receiver cannot stall; each result is shown once.
// ----------------------------------------------------------------------------
module modular_power_prime_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mpp_pkg::MOD_W-1:0]     base,
    input  logic [mpp_pkg::EXP_IN_W-1:0]  exponent,
    output logic                          done,
    output logic [mpp_pkg::MOD_W-1:0]     power
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_QEST,
        ST_QMUL,
        ST_FIX
    } state_t;

    state_t                           state_reg, state_next;
    logic [mpp_pkg::MOD_W-1:0]        base_reg, base_next;
    logic [mpp_pkg::MOD_W-1:0]        acc_reg, acc_next;
    logic [mpp_pkg::EXP_BITS-1:0]     exp_reg, exp_next;
    logic [mpp_pkg::CNT_W-1:0]        bits_left_reg, bits_left_next;
    logic                             mul_base_reg, mul_base_next;
    logic [mpp_pkg::SQ_W-1:0]         prod_reg, prod_next;
    logic [mpp_pkg::MUL_W-1:0]        q_reg, q_next;
    logic [mpp_pkg::REM_W-1:0]        qp_reg, qp_next;
    logic                             done_reg, done_next;
    logic [mpp_pkg::MOD_W-1:0]        power_reg, power_next;

    logic [mpp_pkg::MUL_W-1:0]        mult_a;
    logic [mpp_pkg::MUL_W-1:0]        mult_b;
    logic [mpp_pkg::PROD_W-1:0]       product;
    logic [mpp_pkg::REM_W-1:0]        rem;
    logic [mpp_pkg::REM_W-1:0]        rem_p;
    logic [mpp_pkg::REM_W-1:0]        rem_2p;
    logic [mpp_pkg::MOD_W-1:0]        fix_val;
    logic [mpp_pkg::MOD_W-1:0]        base_red;

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign power = power_reg;

    // shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_MUL:
            begin
                mult_a = {1'b0, acc_reg};
                mult_b = mul_base_reg ? {1'b0, base_reg} : {1'b0, acc_reg};
            end
            ST_QEST:
            begin
                mult_a = prod_reg[mpp_pkg::SQ_W-1:mpp_pkg::MOD_W-1];
                mult_b = mpp_pkg::BARRETT_M;
            end
            ST_QMUL:
            begin
                mult_a = q_reg;
                mult_b = {1'b0, mpp_pkg::PRIME_MOD};
            end
            default:
            begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign product = mult_a * mult_b;

    assign rem    = prod_reg[mpp_pkg::REM_W-1:0] - qp_reg;
    assign rem_p  = rem - mpp_pkg::PRIME_R;
    assign rem_2p = rem - mpp_pkg::PRIME_X2;

    always_comb
    begin
        priority if (rem >= mpp_pkg::PRIME_X2)
            fix_val = rem_2p[mpp_pkg::MOD_W-1:0];
        else if (rem >= mpp_pkg::PRIME_R)
            fix_val = rem_p[mpp_pkg::MOD_W-1:0];
        else
            fix_val = rem[mpp_pkg::MOD_W-1:0];
    end

    assign base_red = (base >= mpp_pkg::PRIME_MOD) ? (base - mpp_pkg::PRIME_MOD) : base;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        exp_next       = exp_reg;
        bits_left_next = bits_left_reg;
        mul_base_next  = mul_base_reg;
        prod_next      = prod_reg;
        q_next         = q_reg;
        qp_next        = qp_reg;
        done_next      = 1'b0;
        power_next     = power_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    base_next      = base_red;
                    exp_next       = mpp_pkg::EXP_BITS'(exponent);
                    acc_next       = mpp_pkg::MOD_W'(1);
                    bits_left_next = mpp_pkg::CNT_W'(mpp_pkg::EXP_BITS);
                    mul_base_next  = 1'b0;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = product[mpp_pkg::SQ_W-1:0];
                state_next = ST_QEST;
            end
            ST_QEST:
            begin
                q_next     = product[mpp_pkg::PROD_W-1:mpp_pkg::MOD_W+1];
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                qp_next    = product[mpp_pkg::REM_W-1:0];
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                acc_next = fix_val;
                if (!mul_base_reg && exp_reg[mpp_pkg::EXP_BITS-1])
                begin
                    mul_base_next = 1'b1;
                    state_next    = ST_MUL;
                end
                else
                begin
                    // advance to the next exponent bit
                    mul_base_next  = 1'b0;
                    exp_next       = exp_reg << 1;
                    bits_left_next = bits_left_reg - mpp_pkg::CNT_W'(1);
                    if (bits_left_reg == mpp_pkg::CNT_W'(1))
                    begin
                        done_next  = 1'b1;
                        power_next = fix_val;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            acc_reg       <= '0;
            exp_reg       <= '0;
            bits_left_reg <= '0;
            mul_base_reg  <= 1'b0;
            prod_reg      <= '0;
            q_reg         <= '0;
            qp_reg        <= '0;
            done_reg      <= 1'b0;
            power_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            acc_reg       <= acc_next;
            exp_reg       <= exp_next;
            bits_left_reg <= bits_left_next;
            mul_base_reg  <= mul_base_next;
            prod_reg      <= prod_next;
            q_reg         <= q_next;
            qp_reg        <= qp_next;
            done_reg      <= done_next;
            power_reg     <= power_next;
        end
    end

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (power_reg < mpp_pkg::PRIME_MOD))
        else $error("result not reduced");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (acc_reg < mpp_pkg::PRIME_MOD))
        else $error("partial result not reduced");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (rem < mpp_pkg::PRIME_X3))
        else $error("Barrett remainder out of bound");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done_reg))
        else $error("accepted item did not start");
`endif

endmodule
